/* sv/ring_fifo_overwrite_search_defines.svh */
// Assertion helpers for the RTL file that checks its own logic.
`ifndef RING_FIFO_OVERWRITE_SEARCH_DEFINES_SVH
`define RING_FIFO_OVERWRITE_SEARCH_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RFOS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RFOS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/rfos_pkg.sv */
package rfos_pkg;

  localparam int RING_DEPTH_DEF   = 16;
  localparam int ELEMENT_BITS_DEF = 32;

  localparam int CMD_W      = 3;
  localparam int POS_W      = 4;
  localparam int CNT_OUT_W  = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  // slots_in_use after reset, before clamping to the ring depth
  localparam int SLOTS_RESET = 16;

  localparam logic [CFG_IDX_W-1:0] REG_OVERFLOW_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE  = 2'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_READ   = 3'd2,
    CMD_WRITE  = 3'd3,
    CMD_SEARCH = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_INDEX = 2'd3
  } stat_t;

  // Broadcast controls from the sequencer to every cell
  typedef struct packed {
    logic wr;    // store wdata in the cell addressed by wptr
    logic seed;  // place the search token on the cell addressed by seed_ptr
    logic adv;   // move the token one cell toward the newest entry
    logic clr;   // drop the token
  } cell_ctl_t;

  // What one cell reports back
  typedef struct packed {
    logic fwd;   // token leaves toward the next cell
    logic wrap;  // token leaves the last slot in use, back to cell 0
    logic hit;   // token sits here and the entry equals the key
  } cell_st_t;

endpackage

/* sv/ring_fifo_overwrite_search.sv */
// Circular FIFO with overwrite and search. The ring is a row of cells, one
// element each, of which slots_in_use (clamped to 2..RING_DEPTH) are used; one
// slot always stays empty, so capacity is slots_in_use - 1. Push, pop, read at
// index, write at index, clear and unknown commands are each handled when accepted: the
// result is registered and the next command is taken in the following cycle
// as long as the result side keeps up. Search seeds a token on the oldest
// cell and hands it from cell to cell, one compare per cycle, and holds the
// input until the matching entry is found or all entry_count entries have
// been compared; a search of an empty FIFO is answered without a walk.
// Writing slots_in_use empties the FIFO. Every result carries entry_count and
// free_slots after the command. Stored elements power up undefined.
`include "ring_fifo_overwrite_search_defines.svh"

module ring_fifo_overwrite_search #(
  parameter int RING_DEPTH   = rfos_pkg::RING_DEPTH_DEF,
  parameter int ELEMENT_BITS = rfos_pkg::ELEMENT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [rfos_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rfos_pkg::CFG_DATA_W-1:0]   cfg_data,
  // commands
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [rfos_pkg::CMD_W-1:0]        in_command,
  input  logic [rfos_pkg::POS_W-1:0]        in_position,
  input  logic [ELEMENT_BITS-1:0]           in_data_in,
  // results
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_status,
  output logic [ELEMENT_BITS-1:0]           out_data_out,
  output logic [rfos_pkg::CNT_OUT_W-1:0]    out_entry_count,
  output logic [rfos_pkg::CNT_OUT_W-1:0]    out_free_slots
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int CNT_W = PTR_W + 1;
  localparam int SW    = ((CNT_W > rfos_pkg::POS_W) ? CNT_W : rfos_pkg::POS_W) + 1;
  localparam int SLOTS_RST_INT =
    (RING_DEPTH < rfos_pkg::SLOTS_RESET) ? RING_DEPTH : rfos_pkg::SLOTS_RESET;
  localparam logic [CNT_W-1:0] SLOTS_RST = CNT_W'(SLOTS_RST_INT);
  localparam logic [CNT_W-1:0] SLOTS_MIN = CNT_W'(2);
  localparam logic [CNT_W-1:0] SLOTS_MAX = CNT_W'(RING_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } state_t;

  // ---------------------------------------------------------------------
  // Ring arithmetic
  // ---------------------------------------------------------------------
  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p,
                                                 input logic [PTR_W-1:0] lst);
    return (p == lst) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] held(input logic [PTR_W-1:0] o,
                                            input logic [PTR_W-1:0] w,
                                            input logic [CNT_W-1:0] slots);
    logic [CNT_W-1:0] wrapped;
    wrapped = slots - CNT_W'(o) + CNT_W'(w);
    return (w >= o) ? (w - o) : wrapped[PTR_W-1:0];
  endfunction

  // ---------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------
  state_t                    state_r, state_nxt;
  logic                      mode_r, mode_nxt;
  logic [CNT_W-1:0]          slots_r, slots_nxt;
  logic [PTR_W-1:0]          oldest_r, oldest_nxt;
  logic [PTR_W-1:0]          wptr_r, wptr_nxt;
  logic [PTR_W-1:0]          remain_r, remain_nxt;
  logic [ELEMENT_BITS-1:0]   key_r;

  logic                      out_valid_r, out_valid_nxt;
  rfos_pkg::stat_t           out_status_r, res_status;
  logic [ELEMENT_BITS-1:0]   out_data_r, res_data;
  logic [PTR_W-1:0]          out_count_r, res_count;
  logic [CNT_W-1:0]          out_free_r, res_free;

  // ---------------------------------------------------------------------
  // Cell row
  // ---------------------------------------------------------------------
  rfos_pkg::cell_ctl_t       ctl;
  rfos_pkg::cell_st_t        cell_st   [RING_DEPTH];
  logic [ELEMENT_BITS-1:0]   cell_data [RING_DEPTH];
  logic [RING_DEPTH-1:0]     fwd_vec, wrap_vec, hit_vec, tok_vec;
  logic [PTR_W-1:0]          last_ptr;
  logic [PTR_W-1:0]          waddr, raddr;
  logic [ELEMENT_BITS-1:0]   rd_data;

  assign last_ptr = PTR_W'(slots_r - CNT_W'(1));

  for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
    logic tok_in;
    if (i == 0) begin : g_head
      // the token re-enters at cell 0 from whichever cell is the last in use
      assign tok_in = |wrap_vec;
    end else begin : g_body
      assign tok_in = fwd_vec[i-1];
    end

    rfos_cell #(
      .ELEMENT_BITS (ELEMENT_BITS),
      .PTR_W        (PTR_W),
      .IDX          (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .wptr     (waddr),
      .seed_ptr (oldest_r),
      .last_ptr (last_ptr),
      .wdata    (in_data_in),
      .key      (key_r),
      .tok_in   (tok_in),
      .data     (cell_data[i]),
      .st       (cell_st[i])
    );

    assign fwd_vec[i]  = cell_st[i].fwd;
    assign wrap_vec[i] = cell_st[i].wrap;
    assign hit_vec[i]  = cell_st[i].hit;
    assign tok_vec[i]  = cell_st[i].fwd | cell_st[i].wrap;
  end

  assign rd_data = cell_data[raddr];

  // ---------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------
  logic accept;
  logic load_out;

  // hold the input while walking, or while a finished result is refused
  assign in_stall = (state_r == S_WALK) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  // ---------------------------------------------------------------------
  // Command decode and sequencing
  // ---------------------------------------------------------------------
  logic [PTR_W-1:0] cnt_cur;
  logic [SW-1:0]    idx_sum;
  logic [PTR_W-1:0] idx;
  logic             idx_bad;
  logic             full;

  assign cnt_cur = held(oldest_r, wptr_r, slots_r);
  assign full    = (ring_next(wptr_r, last_ptr) == oldest_r);
  assign idx_bad = (SW'(in_position) >= SW'(cnt_cur));

  always_comb begin
    idx_sum = SW'(oldest_r) + SW'(in_position);
    if (idx_sum >= SW'(slots_r)) begin
      idx_sum = idx_sum - SW'(slots_r);
    end
    idx = idx_sum[PTR_W-1:0];
  end

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    slots_nxt  = slots_r;
    oldest_nxt = oldest_r;
    wptr_nxt   = wptr_r;
    remain_nxt = remain_r;
    ctl        = '0;
    waddr      = idx;
    raddr      = idx;
    load_out   = 1'b0;
    res_status = rfos_pkg::STAT_OK;
    res_data   = '0;

    if (accept) begin
      load_out = 1'b1;
      case (rfos_pkg::cmd_t'(in_command))
        rfos_pkg::CMD_PUSH: begin
          waddr = wptr_r;
          if (full && !mode_r) begin
            res_status = rfos_pkg::STAT_FULL;
          end else begin
            if (full) begin
              // drop the oldest entry to make room
              oldest_nxt = ring_next(oldest_r, last_ptr);
            end
            ctl.wr   = 1'b1;
            wptr_nxt = ring_next(wptr_r, last_ptr);
          end
        end
        rfos_pkg::CMD_POP: begin
          raddr = oldest_r;
          if (cnt_cur == '0) begin
            res_status = rfos_pkg::STAT_EMPTY;
          end else begin
            res_data   = rd_data;
            oldest_nxt = ring_next(oldest_r, last_ptr);
          end
        end
        rfos_pkg::CMD_READ: begin
          if (idx_bad) begin
            res_status = rfos_pkg::STAT_INDEX;
          end else begin
            res_data = rd_data;
          end
        end
        rfos_pkg::CMD_WRITE: begin
          if (idx_bad) begin
            res_status = rfos_pkg::STAT_INDEX;
          end else begin
            ctl.wr = 1'b1;
          end
        end
        rfos_pkg::CMD_SEARCH: begin
          if (cnt_cur == '0) begin
            res_status = rfos_pkg::STAT_EMPTY;
          end else begin
            // seed the token on the oldest cell and start the walk
            load_out   = 1'b0;
            ctl.seed   = 1'b1;
            remain_nxt = cnt_cur;
            state_nxt  = S_WALK;
          end
        end
        rfos_pkg::CMD_CLEAR: begin
          oldest_nxt = '0;
          wptr_nxt   = '0;
        end
        default: begin
          res_status = rfos_pkg::STAT_INDEX;
        end
      endcase
    end

    if (state_r == S_WALK) begin
      if (|hit_vec) begin
        load_out   = 1'b1;
        ctl.clr    = 1'b1;
        state_nxt  = S_IDLE;
      end else if (remain_r == PTR_W'(1)) begin
        load_out   = 1'b1;
        res_status = rfos_pkg::STAT_EMPTY;
        ctl.clr    = 1'b1;
        state_nxt  = S_IDLE;
      end else begin
        ctl.adv    = 1'b1;
        remain_nxt = remain_r - PTR_W'(1);
      end
    end

    // configuration writes must arrive only while idle; the block does not enforce this
    if (cfg_we) begin
      case (cfg_index)
        rfos_pkg::REG_OVERFLOW_MODE: begin
          mode_nxt = cfg_data[0];
        end
        rfos_pkg::REG_SLOTS_IN_USE: begin
          if (cfg_data < rfos_pkg::CFG_DATA_W'(2)) begin
            slots_nxt = SLOTS_MIN;
          end else if (int'(cfg_data) > RING_DEPTH) begin
            slots_nxt = SLOTS_MAX;
          end else begin
            slots_nxt = CNT_W'(cfg_data);
          end
          oldest_nxt = '0;
          wptr_nxt   = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // fill level reported with every result, taken after the command
  assign res_count = held(oldest_nxt, wptr_nxt, slots_r);
  assign res_free  = slots_r - CNT_W'(1) - CNT_W'(res_count);

  // the output register frees when its transfer completes
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= 1'b0;
      slots_r     <= SLOTS_RST;
      oldest_r    <= '0;
      wptr_r      <= '0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      slots_r     <= slots_nxt;
      oldest_r    <= oldest_nxt;
      wptr_r      <= wptr_nxt;
      remain_r    <= remain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.seed) begin
      key_r <= in_data_in;
    end
    if (load_out) begin
      out_status_r <= res_status;
      out_data_r   <= res_data;
      out_count_r  <= res_count;
      out_free_r   <= res_free;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_data_out    = out_data_r;
  assign out_entry_count = rfos_pkg::CNT_OUT_W'(out_count_r);
  assign out_free_slots  = rfos_pkg::CNT_OUT_W'(out_free_r);

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `RFOS_ASSERT_NOW(a_tok_onehot, 1'b1, $onehot0(tok_vec), "search token on more than one cell")
  `RFOS_ASSERT_NOW(a_walk_has_tok, state_r == S_WALK, $onehot(tok_vec), "walk without token")
  `RFOS_ASSERT_NOW(a_no_clobber, load_out, !(out_valid_r && out_stall), "result overwritten")
  `RFOS_ASSERT_NOW(a_count_cap, 1'b1, CNT_W'(cnt_cur) < slots_r, "count beyond capacity")
  `RFOS_ASSERT_NEXT(a_seed_walk, ctl.seed, state_r == S_WALK, "seed without walk")

endmodule

/* sv/rfos_cell.sv */
module rfos_cell #(
  parameter int ELEMENT_BITS = rfos_pkg::ELEMENT_BITS_DEF,
  parameter int PTR_W        = 4,
  parameter int IDX          = 0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  rfos_pkg::cell_ctl_t     ctl,
  input  logic [PTR_W-1:0]        wptr,
  input  logic [PTR_W-1:0]        seed_ptr,
  input  logic [PTR_W-1:0]        last_ptr,
  input  logic [ELEMENT_BITS-1:0] wdata,
  input  logic [ELEMENT_BITS-1:0] key,
  input  logic                    tok_in,
  output logic [ELEMENT_BITS-1:0] data,
  output rfos_pkg::cell_st_t      st
);

  localparam logic [PTR_W-1:0] MY_IDX = PTR_W'(IDX);

  logic [ELEMENT_BITS-1:0] data_r;
  logic                    tok_r;
  logic                    tok_nxt;
  logic                    is_last;

  assign is_last = (last_ptr == MY_IDX);

  always_comb begin
    tok_nxt = tok_r;
    if (ctl.seed) begin
      tok_nxt = (seed_ptr == MY_IDX);
    end else if (ctl.clr) begin
      tok_nxt = 1'b0;
    end else if (ctl.adv) begin
      tok_nxt = tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr && (wptr == MY_IDX)) begin
      data_r <= wdata;
    end
  end

  assign data    = data_r;
  assign st.fwd  = tok_r && !is_last;
  assign st.wrap = tok_r && is_last;
  assign st.hit  = tok_r && (data_r == key);

endmodule
